>>> sv/sfp_crc_pkg.sv
// Shared types and constants for the framed serial packet parser.
// No dependencies; imported by sfp_crc16_byte and serial_frame_parser_crc16_core.
`default_nettype none

package sfp_crc_pkg;

    localparam int unsigned TRAILER_BYTES = 4;
    localparam int unsigned TRAIL_CNT_W   = $clog2(TRAILER_BYTES);

    localparam logic [7:0]  HDR_FIRST      = 8'h81;
    localparam logic [7:0]  HDR_SECOND     = 8'hAA;
    localparam logic [7:0]  TAIL_FIRST     = 8'h55;
    localparam logic [7:0]  TAIL_SECOND    = 8'h81;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL  = 16'hA001;
    localparam logic [15:0] CRC_XOR_OUT    = 16'hFFFF;
    localparam logic [15:0] LIMIT_RESET    = 16'd256;

    // Count of length bytes already taken when the body starts.
    localparam logic [15:0] LEN_BYTES      = 16'd2;
    // Stored-count values at which the command word bytes arrive.
    localparam logic [15:0] CMD_HI_POS     = 16'd4;
    localparam logic [15:0] CMD_LO_POS     = 16'd5;
    // Body bytes beyond the length field value.
    localparam logic [16:0] BODY_EXTRA     = 17'd4;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_WAIT_AA = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_BODY    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_OVERFLOW = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [15:0] command_word;
        logic [15:0] length_field;
        logic [15:0] computed_crc;
    } result_t;

endpackage

`default_nettype wire

>>> sv/sfp_crc16_byte.sv
// One-byte update of the reflected CRC-16 (poly 0xA001), eight bit steps unrolled.
// Depends on sfp_crc_pkg for the polynomial.
`default_nettype none

module sfp_crc16_byte
    import sfp_crc_pkg::*;
(
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data,
    output logic      [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

>>> sv/serial_frame_parser_crc16_core.sv
// Top level of the framed serial packet parser with on-the-fly CRC-16/USB check.
// Depends on sfp_crc_pkg and sfp_crc16_byte.
//
//  Channel   Signals                        Direction  Content
//  --------  -----------------------------  ---------  ------------------------------
//  s (in)    s_tvalid s_tready s_tdata      slave      one received byte per request
//            s_tuser                                   plus the resync flag
//  m (out)   m_tvalid m_tready m_tdata      master     one result request per frame
//            m_tuser                                   (status in tuser)
//  cfg       cfg_we cfg_wdata               write      frame_byte_limit register
//
// Each input request is handled in the cycle it is accepted: only the parser's
// combinational logic and the 8-step CRC update sit between the input and the result
// register, so one byte per clock is sustained while s_tready is high. The result
// path is a two-entry output stage (output register plus skid register); s_tready
// drops only when both hold results, that is after two results sit unread. Reset
// (rst_n, async, active low) puts the parser in header hunt with the limit at 256.
`default_nettype none

module serial_frame_parser_crc16_core
    import sfp_crc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] resync
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // [15:0] command_word, [31:16] length_field,
                                        // [47:32] computed_crc
    output logic      [1:0]  m_tuser,   // [1:0] frame_status
    // Configuration.
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    // Parser state.
    phase_t                 phase_reg, phase_next;
    logic [16:0]            remain_reg, remain_next;
    logic [15:0]            crc_reg, crc_next;
    logic [15:0]            stored_reg, stored_next;
    logic [15:0]            len_reg, len_next;
    logic [15:0]            cmd_reg, cmd_next;
    logic [TRAIL_CNT_W-1:0] tcnt_reg, tcnt_next;
    logic                   mis_reg, mis_next;
    logic [15:0]            limit_reg;

    // Output stage.
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    // State after an optional resync, seen by this byte.
    phase_t                 ph_eff;
    logic [16:0]            remain_eff;
    logic [15:0]            crc_eff, stored_eff, len_eff, cmd_eff;
    logic [TRAIL_CNT_W-1:0] tcnt_eff;
    logic                   mis_eff;

    logic [7:0]  rx_byte;
    logic        resync;
    logic        accept;
    logic [15:0] crc_upd;
    logic [15:0] crc_final;
    logic [15:0] stored_inc;
    logic        byte_mis;
    logic        emit;
    result_t     res;
    logic        out_fire;

    assign rx_byte  = s_tdata;
    assign resync   = s_tuser[0];
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;

    always_comb
    begin
        if (resync)
        begin
            ph_eff     = PH_HUNT;
            remain_eff = '0;
            crc_eff    = CRC_INIT;
            stored_eff = '0;
            len_eff    = '0;
            cmd_eff    = '0;
            tcnt_eff   = '0;
            mis_eff    = 1'b0;
        end
        else
        begin
            ph_eff     = phase_reg;
            remain_eff = remain_reg;
            crc_eff    = crc_reg;
            stored_eff = stored_reg;
            len_eff    = len_reg;
            cmd_eff    = cmd_reg;
            tcnt_eff   = tcnt_reg;
            mis_eff    = mis_reg;
        end
    end

    sfp_crc16_byte u_crc
    (
        .crc_in  (crc_eff),
        .data    (rx_byte),
        .crc_out (crc_upd)
    );

    assign stored_inc = stored_eff + 16'd1;

    // The CRC does not move during the trailer, so compare against the current value.
    assign crc_final = crc_eff ^ CRC_XOR_OUT;

    always_comb
    begin
        case (tcnt_eff)
            2'd0:    byte_mis = (rx_byte != crc_final[15:8]);
            2'd1:    byte_mis = (rx_byte != crc_final[7:0]);
            2'd2:    byte_mis = (rx_byte != TAIL_FIRST);
            default: byte_mis = (rx_byte != TAIL_SECOND);
        endcase
    end

    // Next phase of the header/length/body state machine.
    always_comb
    begin
        unique case (ph_eff)
            PH_HUNT:
                phase_next = (rx_byte == HDR_FIRST) ? PH_WAIT_AA : PH_HUNT;
            PH_WAIT_AA:
                if (rx_byte == HDR_SECOND)
                    phase_next = PH_LEN_HI;
                else if (rx_byte == HDR_FIRST)
                    phase_next = PH_WAIT_AA;
                else
                    phase_next = PH_HUNT;
            PH_LEN_HI:
                phase_next = (rx_byte == HDR_FIRST) ? PH_WAIT_AA : PH_LEN_LO;
            PH_LEN_LO:
                phase_next = PH_BODY;
            PH_BODY:
                phase_next = emit ? PH_HUNT : PH_BODY;
            default:
                phase_next = PH_HUNT;
        endcase
    end

    // Datapath and result decisions.
    always_comb
    begin
        remain_next = remain_eff;
        crc_next    = crc_eff;
        stored_next = stored_eff;
        len_next    = len_eff;
        cmd_next    = cmd_eff;
        tcnt_next   = tcnt_eff;
        mis_next    = mis_eff;
        emit        = 1'b0;
        res.frame_status = ST_GOOD;
        res.command_word = cmd_eff;
        res.length_field = len_eff;
        res.computed_crc = crc_final;

        unique case (ph_eff) inside
            PH_HUNT, PH_WAIT_AA:
            begin
                // A non-header byte while waiting for 0xAA rearms; state is already clear.
            end
            PH_LEN_HI:
                if (rx_byte != HDR_FIRST)
                begin
                    len_next = {rx_byte, 8'h00};
                    crc_next = crc_upd;
                end
            PH_LEN_LO:
            begin
                len_next    = {len_eff[15:8], rx_byte};
                crc_next    = crc_upd;
                stored_next = LEN_BYTES;
                remain_next = {1'b0, len_eff[15:8], rx_byte} + BODY_EXTRA;
            end
            PH_BODY:
                if (remain_eff != '0)
                begin
                    remain_next = remain_eff - 17'd1;
                    if (stored_eff == CMD_HI_POS)
                        cmd_next = {rx_byte, cmd_eff[7:0]};
                    else if (stored_eff == CMD_LO_POS)
                        cmd_next = {cmd_eff[15:8], rx_byte};
                    crc_next    = crc_upd;
                    stored_next = stored_inc;
                    if (stored_inc >= limit_reg)
                    begin
                        emit             = 1'b1;
                        res.frame_status = ST_OVERFLOW;
                        res.command_word = cmd_next;
                        res.computed_crc = crc_upd ^ CRC_XOR_OUT;
                    end
                end
                else
                begin
                    mis_next  = mis_eff | byte_mis;
                    tcnt_next = tcnt_eff + 1'b1;
                    if (tcnt_eff == TRAIL_CNT_W'(TRAILER_BYTES - 1))
                    begin
                        emit             = 1'b1;
                        res.frame_status = (mis_eff | byte_mis) ? ST_MISMATCH : ST_GOOD;
                    end
                end
            default:
            begin
                remain_next = '0;
                crc_next    = CRC_INIT;
                stored_next = '0;
                len_next    = '0;
                cmd_next    = '0;
                tcnt_next   = '0;
                mis_next    = 1'b0;
            end
        endcase

        // Every result rearms the parser.
        if (emit)
        begin
            remain_next = '0;
            crc_next    = CRC_INIT;
            stored_next = '0;
            len_next    = '0;
            cmd_next    = '0;
            tcnt_next   = '0;
            mis_next    = 1'b0;
        end
    end

    // Parser state registers: updated only when a byte is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            remain_reg <= '0;
            crc_reg    <= CRC_INIT;
            stored_reg <= '0;
            len_reg    <= '0;
            cmd_reg    <= '0;
            tcnt_reg   <= '0;
            mis_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            crc_reg    <= crc_next;
            stored_reg <= stored_next;
            len_reg    <= len_next;
            cmd_reg    <= cmd_next;
            tcnt_reg   <= tcnt_next;
            mis_reg    <= mis_next;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    // Output register with a skid register behind it. The skid register fills
    // only when a new result arrives while the output register is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= accept && emit;
            end
            else
            begin
                out_valid_reg <= accept && emit;
            end
        end
        else if (accept && emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
        else if (accept && emit)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.computed_crc, out_reg.length_field, out_reg.command_word};
    assign m_tuser  = out_reg.frame_status;

endmodule

`default_nettype wire
